FILE: hdl/rdc_pkg.sv
// Shared types and constants for the radix digit converter.
// No dependencies; rdc_divider and radix_digit_converter_top import this package.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int RADIX_W = 9;
  localparam int PAD_W   = 7;
  localparam int DIGIT_W = 8;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD   = 1'd1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 9'd256;
  localparam logic [RADIX_W-1:0] RADIX_RST = 9'd10;

  // Status reported by the serial divider at the end of one division pass.
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               more;
  } div_status_t;

endpackage

FILE: hdl/rdc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rdc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, remainder is a digit.
// Depends on rdc_pkg for the status struct and field widths.
`timescale 1ns / 1ps

module rdc_divider #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        again,
  input  logic [VALUE_WIDTH-1:0]      dividend,
  input  logic [rdc_pkg::RADIX_W-1:0] radix,
  output rdc_pkg::div_status_t        status
);
  import rdc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quot;
  logic [DIGIT_W-1:0]     rem;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   qnz;
  logic                   done;

  logic [RADIX_W-1:0]     trial;
  logic                   fits;
  logic [DIGIT_W-1:0]     rem_next;

  // Shift the next dividend bit into the partial remainder and subtract
  // the radix where it fits; the remainder always stays below 256.
  always_comb begin
    trial    = {rem, quot[VALUE_WIDTH-1]};
    fits     = (trial >= radix);
    rem_next = fits ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start || again) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(VALUE_WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
    end else if (busy) begin
      quot <= {quot[VALUE_WIDTH-2:0], fits};
    end
    if (start || again) begin
      rem <= '0;
      cnt <= '0;
      qnz <= 1'b0;
    end else if (busy) begin
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      qnz <= qnz | fits;
    end
  end

  assign status.done  = done;
  assign status.digit = rem;
  assign status.more  = qnz;

endmodule

FILE: hdl/radix_digit_converter_top.sv
// Radix digit converter: top level with the item sequencer and output register.
// Depends on rdc_pkg, rdc_divider and rdc_ram.
`timescale 1ns / 1ps

// Converts each accepted unsigned value into its digits in the base held in
// the radix register and sends them most significant first, one digit per
// output item, with tlast on the final digit. Leading zero digits are added
// until the count reaches pad_width; a value of zero with a pad width of zero
// produces no output items. A radix below 2 acts as 2 and one above 256 acts
// as 256; a pad width above MAX_DIGITS acts as MAX_DIGITS. Digits are found
// least significant first by a bit-serial divider, parked in a small RAM, then
// read back in reverse order at one digit per cycle while the receiver keeps
// taking them. One item is worked on at a time; the next item is taken once
// the last digit of the previous one has been loaded into the output
// register. Configuration must be written only while the block is idle.
module radix_digit_converter_top #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdc_pkg::CFG_W-1:0]     cfg_data,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // [63:0] value
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] digit
  output logic                          m_axis_tlast
);
  import rdc_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0]         state;
  logic [RADIX_W-1:0] radix_reg;
  logic [PAD_W-1:0]   pad_reg;
  logic [CW-1:0]      n_digits;
  logic [CW-1:0]      rem_cnt;

  logic [RADIX_W-1:0] radix_eff;
  logic [CW-1:0]      pad_sat;
  logic [CW-1:0]      total;
  logic [CW-1:0]      pos;
  logic               adv;
  logic               accept;
  logic               val_zero;
  logic               div_again;
  logic [AW-1:0]      raddr;
  logic [DIGIT_W-1:0] rdata;
  div_status_t        div_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RADIX_RST;
      pad_reg   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX: radix_reg <= cfg_data;
        REG_PAD:   pad_reg   <= cfg_data[PAD_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (radix_reg < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_reg > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_reg;
    end
    pad_sat = (pad_reg > PAD_W'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(pad_reg);
    total   = (n_digits > pad_sat) ? n_digits : pad_sat;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign val_zero      = (s_axis_tdata[VALUE_WIDTH-1:0] == '0);

  // Start another division pass while the quotient is nonzero and the buffer
  // still has room for a digit that could ever be sent.
  assign div_again = (state == S_DIV) && div_status.done && div_status.more &&
                     (n_digits != CW'(MAX_DIGITS - 1));

  rdc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !val_zero),
    .again    (div_again),
    .dividend (s_axis_tdata[VALUE_WIDTH-1:0]),
    .radix    (radix_eff),
    .status   (div_status)
  );

  // Read side: the digit at position pos is addressed ahead of its load through the
  // registered RAM read port, and the address steps down as soon as the output register takes it.
  always_comb begin
    pos = rem_cnt - 1'b1;
    adv = (state == S_LOAD) && (!m_axis_tvalid || m_axis_tready);
    if (adv) begin
      raddr = AW'(pos - 1'b1);
    end else begin
      raddr = pos[AW-1:0];
    end
  end

  rdc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_buf (
    .clk   (clk),
    .we    ((state == S_DIV) && div_status.done),
    .waddr (n_digits[AW-1:0]),
    .wdata (div_status.digit),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      n_digits      <= '0;
      rem_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The output register is refilled when it loads a digit and empties
      // once the receiver takes what it holds.
      if (adv) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            n_digits <= '0;
            state    <= val_zero ? S_SETUP : S_DIV;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            n_digits <= n_digits + 1'b1;
            if (!div_again) begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (total == '0) begin
            state <= S_IDLE;
          end else begin
            rem_cnt <= total;
            state   <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (adv) begin
            rem_cnt <= rem_cnt - 1'b1;
            if (rem_cnt == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload: padding positions above the significant digits read as zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= (pos < n_digits) ? rdata : '0;
      m_axis_tlast <= (rem_cnt == CW'(1));
    end
  end

endmodule
